### rtl/core/whps_pkg.sv
// ----------------------------------------------------------------------------
// whps_pkg
// Shared types, codes and constants of the weighted hash peer selector.
// ----------------------------------------------------------------------------
`default_nettype none

package whps_pkg;

  localparam int MAX_PEERS    = 32;
  localparam int MAX_TRIES    = 20;
  localparam int PEER_AW      = $clog2(MAX_PEERS);
  localparam int PCNT_W       = $clog2(MAX_PEERS + 1);
  localparam int TW_W         = 13;
  localparam int DIV_STEPS    = 32;
  localparam int DIV_CW       = $clog2(DIV_STEPS);
  localparam int CFG_DW       = 13;
  localparam logic [1:0] REHASH_LIMIT = 2'd3;

  typedef enum logic [1:0] {
    MODE_LOAD   = 2'd0,
    MODE_BEGIN  = 2'd1,
    MODE_SELECT = 2'd2,
    MODE_NONE   = 2'd3
  } mode_e;

  typedef enum logic {
    CFG_PEER_COUNT = 1'b0,
    CFG_WEIGHT_SUM = 1'b1
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MOD_GO,
    ST_MOD_WAIT,
    ST_WALK_RD,
    ST_WALK_CMP
  } state_e;

  typedef struct packed {
    logic [1:0]  mode;
    logic [4:0]  peer_index;
    logic [7:0]  weight;
    logic        peer_down;
    logic [7:0]  fail_limit;
    logic [7:0]  fails;
    logic [15:0] fail_tmo;
    logic [15:0] conn_limit;
    logic [15:0] conns;
    logic [31:0] time_value;
    logic [31:0] key_hash;
    logic        key_empty;
  } in_t;

  typedef struct packed {
    logic [4:0]  selected_peer;
    logic        peer_found;
    logic        use_fallback;
    logic [31:0] hash_value;
  } out_t;

  typedef struct packed {
    logic [7:0]  weight;
    logic        down;
    logic [7:0]  fail_limit;
    logic [7:0]  fail_count;
    logic [15:0] timeout;
    logic [15:0] conn_limit;
    logic [15:0] conn_count;
    logic [31:0] checked;
  } entry_t;

  // crc-32 of the single ascii digit of the rehash count
  function automatic logic [31:0] rehash_crc(input logic [1:0] r);
    logic [31:0] c;
    case (r)
      2'd1:    c = 32'h83DC_EFB7;
      2'd2:    c = 32'h1AD5_BE0D;
      2'd3:    c = 32'h6DD2_8E9B;
      default: c = 32'h0000_0000;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

### rtl/core/weighted_hash_peer_select_top.sv
// ----------------------------------------------------------------------------
// weighted_hash_peer_select_top
// Weighted hash peer selection over a peer table held in one synchronous ram.
// ----------------------------------------------------------------------------
// load, begin and unused modes: result strobe in the cycle after the start beat,
// next beat may follow at once.
// select: result in the cycle after the beat on early fallback, else after up to 21
// tries, each a 32-step remainder pass and a one-read-per-cycle weight walk;
// results cannot stall.
// reset clears control state and peer count, sets weight sum to 1; datapath regs and table entries stay undefined.
// ----------------------------------------------------------------------------
`default_nettype none

module weighted_hash_peer_select_top import whps_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start,
  output logic                   busy,
  input  wire in_t               item_i,
  output logic                   done_o,
  output out_t                   res_o,
  input  wire logic              cfg_we_i,
  input  wire logic              cfg_idx_i,
  input  wire logic [CFG_DW-1:0] cfg_data_i
);

  state_e              state_q, state_d;
  logic [PCNT_W-1:0]   peer_count_q;
  logic [TW_W-1:0]     weight_sum_q;
  logic [MAX_PEERS-1:0] tried_q, tried_d;
  logic [4:0]          try_q, try_d;
  logic [1:0]          rehash_q, rehash_d;
  logic [31:0]         req_hash_q, req_hash_d;
  logic                req_empty_q, req_empty_d;
  logic [31:0]         now_q, now_d;
  logic [PCNT_W-1:0]   n_q, n_d;
  logic [31:0]         hash_q, hash_d;
  logic [TW_W-1:0]     w_q, w_d;
  logic [PEER_AW-1:0]  p_q, p_d;
  logic                done_q, done_d;
  out_t                res_q, res_d;

  logic                ram_we;
  logic [PEER_AW-1:0]  ram_waddr;
  entry_t              ram_wdata;
  logic [PEER_AW-1:0]  ram_raddr;
  entry_t              ram_rdata;
  logic                div_start;
  logic                div_done;
  logic [TW_W-1:0]     div_rem;
  logic [TW_W-1:0]     tw_eff;

  logic signed [33:0]  diff;
  logic                expired;
  logic                skip;
  logic [5:0]          next_try;
  logic [PCNT_W:0]     p_next;

  assign tw_eff = (weight_sum_q == '0) ? TW_W'(1) : weight_sum_q;

  // signed distance from last check to now, no wrap
  assign diff    = $signed({2'b00, now_q}) - $signed({2'b00, ram_rdata.checked});
  assign expired = diff > $signed({18'd0, ram_rdata.timeout});
  assign skip    = tried_q[p_q] || ram_rdata.down
                || (ram_rdata.fail_limit != '0
                    && ram_rdata.fail_count >= ram_rdata.fail_limit && !expired)
                || (ram_rdata.conn_limit != '0
                    && ram_rdata.conn_count >= ram_rdata.conn_limit);
  assign next_try = {1'b0, try_q} + 6'd1;
  assign p_next   = {1'b0, p_q} + (PCNT_W + 1)'(1);

  whps_peer_ram u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  whps_mod_unit u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (hash_d),
    .divisor_i  (tw_eff),
    .done_o     (div_done),
    .rem_o      (div_rem)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      peer_count_q <= '0;
      weight_sum_q <= TW_W'(1);
      tried_q      <= '0;
      try_q        <= '0;
      rehash_q     <= '0;
      req_hash_q   <= '0;
      req_empty_q  <= 1'b1;
      done_q       <= 1'b0;
    end else begin
      state_q     <= state_d;
      tried_q     <= tried_d;
      try_q       <= try_d;
      rehash_q    <= rehash_d;
      req_hash_q  <= req_hash_d;
      req_empty_q <= req_empty_d;
      done_q      <= done_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_PEER_COUNT: peer_count_q <= cfg_data_i[PCNT_W-1:0];
          CFG_WEIGHT_SUM: weight_sum_q <= cfg_data_i[TW_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    now_q  <= now_d;
    n_q    <= n_d;
    hash_q <= hash_d;
    w_q    <= w_d;
    p_q    <= p_d;
    res_q  <= res_d;
  end

  always_comb begin
    state_d     = state_q;
    tried_d     = tried_q;
    try_d       = try_q;
    rehash_d    = rehash_q;
    req_hash_d  = req_hash_q;
    req_empty_d = req_empty_q;
    now_d       = now_q;
    n_d         = n_q;
    hash_d      = hash_q;
    w_d         = w_q;
    p_d         = p_q;
    done_d      = 1'b0;
    res_d       = res_q;
    div_start   = 1'b0;
    ram_we      = 1'b0;
    ram_waddr   = item_i.peer_index;
    ram_raddr   = p_q;
    ram_wdata   = '{weight:     item_i.weight,
                    down:       item_i.peer_down,
                    fail_limit: item_i.fail_limit,
                    fail_count: item_i.fails,
                    timeout:    item_i.fail_tmo,
                    conn_limit: item_i.conn_limit,
                    conn_count: item_i.conns,
                    checked:    item_i.time_value};

    case (state_q)
      ST_IDLE: begin
        if (start) begin
          res_d = '0;
          case (mode_e'(item_i.mode))
            MODE_LOAD: begin
              ram_we = 1'b1;
              done_d = 1'b1;
            end
            MODE_BEGIN: begin
              req_hash_d  = item_i.key_hash;
              req_empty_d = item_i.key_empty;
              tried_d     = '0;
              try_d       = '0;
              rehash_d    = '0;
              done_d      = 1'b1;
            end
            MODE_SELECT: begin
              now_d = item_i.time_value;
              n_d   = (peer_count_q > PCNT_W'(MAX_PEERS)) ? PCNT_W'(MAX_PEERS)
                                                          : peer_count_q;
              if (try_q > 5'(MAX_TRIES) || n_d < PCNT_W'(2) || req_empty_q) begin
                res_d.use_fallback = 1'b1;
                done_d             = 1'b1;
              end else begin
                state_d = ST_MOD_GO;
              end
            end
            default: begin
              done_d = 1'b1;
            end
          endcase
        end
      end
      ST_MOD_GO: begin
        hash_d    = (rehash_q != '0) ? rehash_crc(rehash_q) : req_hash_q;
        div_start = 1'b1;
        state_d   = ST_MOD_WAIT;
      end
      ST_MOD_WAIT: begin
        if (div_done) begin
          w_d     = div_rem;
          p_d     = '0;
          state_d = ST_WALK_RD;
        end
      end
      ST_WALK_RD: begin
        state_d = ST_WALK_CMP;
      end
      ST_WALK_CMP: begin
        if (p_next < (PCNT_W + 1)'(n_q) && w_q >= TW_W'(ram_rdata.weight)) begin
          w_d     = w_q - TW_W'(ram_rdata.weight);
          p_d     = p_next[PEER_AW-1:0];
          ram_raddr = p_next[PEER_AW-1:0];
          state_d = ST_WALK_CMP;
        end else if (!skip) begin
          // claim the peer: bump connections (saturating), refresh check time if expired
          ram_we    = 1'b1;
          ram_waddr = p_q;
          ram_wdata = ram_rdata;
          if (ram_rdata.conn_count != 16'hFFFF) begin
            ram_wdata.conn_count = ram_rdata.conn_count + 16'd1;
          end
          if (expired) begin
            ram_wdata.checked = now_q;
          end
          tried_d[p_q]        = 1'b1;
          res_d               = '0;
          res_d.selected_peer = p_q;
          res_d.peer_found    = 1'b1;
          res_d.hash_value    = hash_q;
          done_d              = 1'b1;
          state_d             = ST_IDLE;
        end else begin
          try_d = (next_try > 6'd31) ? 5'd31 : next_try[4:0];
          if (next_try > 6'(MAX_TRIES)) begin
            res_d              = '0;
            res_d.use_fallback = 1'b1;
            done_d             = 1'b1;
            state_d            = ST_IDLE;
          end else begin
            rehash_d = (rehash_q == REHASH_LIMIT) ? 2'd0 : rehash_q + 2'd1;
            state_d  = ST_MOD_GO;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign busy   = (state_q != ST_IDLE);
  assign done_o = done_q;
  assign res_o  = res_q;

  // a load beat answers in the next cycle
  a_load_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && item_i.mode == MODE_LOAD |=> done_o)
    else $error("load beat without result");

  a_found_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && res_o.peer_found |-> !res_o.use_fallback)
    else $error("found and fallback together");

  a_none_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !res_o.peer_found |-> res_o.selected_peer == '0 && res_o.hash_value == '0)
    else $error("result fields set without a peer");

  a_try_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_MOD_GO |-> try_q <= 5'(MAX_TRIES))
    else $error("try past the limit");

endmodule

`default_nettype wire

### rtl/core/whps_mod_unit.sv
// ----------------------------------------------------------------------------
// whps_mod_unit
// Restoring remainder unit: 32-bit hash modulo 13-bit weight, one bit a cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module whps_mod_unit import whps_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire logic [31:0]       dividend_i,
  input  wire logic [TW_W-1:0]   divisor_i,
  output logic                   done_o,
  output logic [TW_W-1:0]        rem_o
);

  logic              run_q;
  logic              done_q;
  logic [DIV_CW-1:0] cnt_q;
  logic [31:0]       quo_q;
  logic [TW_W-1:0]   rem_q;
  logic [TW_W-1:0]   div_q;
  logic [TW_W:0]     shifted;
  logic [TW_W:0]     diff;
  logic              ge;

  assign shifted = {rem_q, quo_q[31]};
  assign ge      = shifted >= {1'b0, div_q};
  assign diff    = shifted - {1'b0, div_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= '0;
      end else if (run_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == DIV_CW'(DIV_STEPS - 1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      div_q <= divisor_i;
    end else if (run_q) begin
      quo_q <= {quo_q[30:0], 1'b0};
      rem_q <= ge ? diff[TW_W-1:0] : shifted[TW_W-1:0];
    end
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

`default_nettype wire

### rtl/core/whps_peer_ram.sv
// ----------------------------------------------------------------------------
// whps_peer_ram
// Peer table: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module whps_peer_ram import whps_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               we_i,
  input  wire logic [PEER_AW-1:0] waddr_i,
  input  wire entry_t             wdata_i,
  input  wire logic [PEER_AW-1:0] raddr_i,
  output entry_t                  rdata_o
);

  entry_t mem [MAX_PEERS];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### tb/weighted_hash_peer_select_top_tb.sv
// ----------------------------------------------------------------------------
// weighted_hash_peer_select_top_tb
// Drives peer table loads, request starts and selections through the command
// port, predicts every result beat and checks it against the block's output.
// ----------------------------------------------------------------------------
`default_nettype none

module weighted_hash_peer_select_top_tb import whps_pkg::*;;

  class peer_select_scoreboard;

    logic [7:0]  weight_q   [32];
    logic        down_q     [32];
    logic [7:0]  flimit_q   [32];
    logic [7:0]  fcount_q   [32];
    logic [15:0] tmo_q      [32];
    logic [15:0] climit_q   [32];
    logic [15:0] ccount_q   [32];
    logic [31:0] checked_q  [32];
    logic [31:0] tried;
    logic [4:0]  tries;
    logic [1:0]  rehash;
    logic [31:0] req_hash;
    logic        req_empty;
    logic [5:0]  peer_count;
    logic [12:0] weight_sum;
    out_t        expected_results[$];
    int          errors;

    function new();
      tried = '0; tries = '0; rehash = '0; req_hash = '0; req_empty = 1'b1;
      peer_count = '0; weight_sum = 13'd1; errors = 0;
    endfunction

    function void set_cfg(cfg_idx_e idx, logic [CFG_DW-1:0] data);
      if (idx == CFG_PEER_COUNT) peer_count = data[5:0];
      else weight_sum = data[12:0];
    endfunction

    function logic [31:0] digit_crc(logic [7:0] b);
      logic [31:0] c;
      c = 32'hFFFF_FFFF ^ {24'd0, b};
      for (int k = 0; k < 8; k++) c = c[0] ? (c >> 1) ^ 32'hEDB8_8320 : (c >> 1);
      return ~c;
    endfunction

    function void note_item(in_t it);
      out_t   r;
      int     n, tw, p;
      logic [31:0] h, w;
      longint diff;
      bit     skip;
      int     nxt;
      r = '0;
      case (mode_e'(it.mode))
        MODE_LOAD: begin
          p = it.peer_index;
          weight_q[p] = it.weight;  down_q[p] = it.peer_down;
          flimit_q[p] = it.fail_limit; fcount_q[p] = it.fails;
          tmo_q[p] = it.fail_tmo; climit_q[p] = it.conn_limit;
          ccount_q[p] = it.conns; checked_q[p] = it.time_value;
        end
        MODE_BEGIN: begin
          req_hash = it.key_hash; req_empty = it.key_empty;
          tried = '0; tries = '0; rehash = '0;
        end
        MODE_SELECT: begin
          n  = peer_count > 32 ? 32 : peer_count;
          tw = weight_sum == 0 ? 1 : weight_sum;
          if (tries > MAX_TRIES || n < 2 || req_empty) begin
            r.use_fallback = 1'b1;
          end else begin
            forever begin
              h = rehash != 0 ? digit_crc(8'h30 + rehash) : req_hash;
              w = h % tw;
              p = 0;
              while (p + 1 < n && w >= weight_q[p]) begin
                w -= weight_q[p];
                p++;
              end
              diff = longint'({32'd0, it.time_value}) - longint'({32'd0, checked_q[p]});
              skip = tried[p] || down_q[p] ||
                     (flimit_q[p] != 0 && fcount_q[p] >= flimit_q[p] &&
                      diff <= longint'(tmo_q[p])) ||
                     (climit_q[p] != 0 && ccount_q[p] >= climit_q[p]);
              if (!skip) begin
                if (ccount_q[p] != 16'hFFFF) ccount_q[p]++;
                if (diff > longint'(tmo_q[p])) checked_q[p] = it.time_value;
                tried[p] = 1'b1;
                r.selected_peer = p[4:0];
                r.peer_found = 1'b1;
                r.hash_value = h;
                break;
              end
              nxt = tries + 1;
              tries = nxt > 31 ? 5'd31 : nxt[4:0];
              if (nxt > MAX_TRIES) begin
                r.use_fallback = 1'b1;
                break;
              end
              rehash = rehash == REHASH_LIMIT ? 2'd0 : rehash + 2'd1;
            end
          end
        end
        default: ;
      endcase
      expected_results.push_back(r);
    endfunction

    function void check_result(out_t got);
      out_t e;
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result beat %h", $time, got);
        errors++;
        return;
      end
      e = expected_results.pop_front();
      if (got.selected_peer !== e.selected_peer) begin
        $display("%0t: selected_peer expected %0d actual %0d", $time, e.selected_peer,
                 got.selected_peer);
        errors++;
      end
      if (got.peer_found !== e.peer_found) begin
        $display("%0t: peer_found expected %0b actual %0b", $time, e.peer_found,
                 got.peer_found);
        errors++;
      end
      if (got.use_fallback !== e.use_fallback) begin
        $display("%0t: use_fallback expected %0b actual %0b", $time, e.use_fallback,
                 got.use_fallback);
        errors++;
      end
      if (got.hash_value !== e.hash_value) begin
        $display("%0t: hash_value expected %h actual %h", $time, e.hash_value,
                 got.hash_value);
        errors++;
      end
    endfunction
  endclass

  localparam int IDLE_LIMIT = 20000;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  in_t               item_i = '0;
  logic              done_o;
  out_t              res_o;
  logic              cfg_we_i = 1'b0;
  logic              cfg_idx_i = CFG_PEER_COUNT;
  logic [CFG_DW-1:0] cfg_data_i = '0;

  peer_select_scoreboard sb = new();
  int          idle_cycles = 0;
  logic [31:0] base_time = 32'd1000;
  logic [7:0]  loaded_weight[32];

  weighted_hash_peer_select_top i_dut (
    .clk_i, .rst_ni, .start, .busy, .item_i, .done_o, .res_o,
    .cfg_we_i, .cfg_idx_i, .cfg_data_i
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // results are checked before the beat accepted at the same edge is noted
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (done_o) sb.check_result(res_o);
      if (start && !busy) sb.note_item(item_i);
      if ((start && !busy) || done_o) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  task automatic send_item(in_t it, bit no_gap = 0);
    int gap;
    gap = no_gap ? 0 : ($urandom_range(0, 3) == 0 ? $urandom_range(0, 19) : 0);
    repeat (gap) begin
      @(negedge clk_i);
      start = 1'b0;
    end
    @(negedge clk_i);
    start  = 1'b1;
    item_i = it;
    do @(posedge clk_i); while (busy);
  endtask

  task automatic write_cfg(cfg_idx_e idx, int value);
    @(negedge clk_i);
    start = 1'b0;
    while (sb.expected_results.size() != 0 || busy) @(negedge clk_i);
    cfg_we_i   = 1'b1;
    cfg_idx_i  = idx;
    cfg_data_i = value[CFG_DW-1:0];
    sb.set_cfg(idx, value[CFG_DW-1:0]);
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  function automatic in_t noise_fields();
    in_t        it;
    logic [159:0] raw;
    raw = {$urandom, $urandom, $urandom, $urandom, $urandom};
    it = raw[$bits(in_t)-1:0];
    return it;
  endfunction

  function automatic in_t load_item(int idx, bit extreme);
    in_t it;
    it = noise_fields();
    it.mode = MODE_LOAD;
    it.peer_index = idx[4:0];
    it.weight = extreme ? 8'd255 : ($urandom_range(0, 3) == 0 ? 8'($urandom_range(1, 255))
                                                             : 8'($urandom_range(1, 12)));
    it.peer_down = $urandom_range(0, 7) == 0;
    it.fail_limit = $urandom_range(0, 1) ? 8'd0 : 8'($urandom);
    it.fails = $urandom_range(0, 1) ? 8'(it.fail_limit + $urandom_range(0, 2))
                                    : 8'($urandom);
    it.fail_tmo = $urandom_range(0, 1) ? 16'($urandom_range(0, 40)) : 16'($urandom);
    it.conn_limit = $urandom_range(0, 1) ? 16'd0 : 16'($urandom_range(1, 6));
    it.conns = $urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(0, 6));
    it.time_value = $urandom_range(0, 7) == 0 ? $urandom : base_time - $urandom_range(0, 50);
    loaded_weight[idx] = it.weight;
    return it;
  endfunction

  function automatic in_t begin_item(bit empty);
    in_t it;
    it = noise_fields();
    it.mode = MODE_BEGIN;
    it.key_empty = empty;
    return it;
  endfunction

  function automatic in_t select_item();
    in_t it;
    it = noise_fields();
    it.mode = MODE_SELECT;
    it.time_value = $urandom_range(0, 7) == 0 ? $urandom : base_time + $urandom_range(0, 60);
    return it;
  endfunction

  initial begin
    in_t it;
    int  n, sum, tw, sent;
    int  counts[6];
    counts = '{0, 1, 2, 32, 40, 63};
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: fill the whole table first so no selection reads a blank entry
    for (int i = 0; i < 32; i++) send_item(load_item(i, i == 31), 1);
    write_cfg(CFG_PEER_COUNT, 32);
    write_cfg(CFG_WEIGHT_SUM, 8160);
    send_item(select_item());           // key empty after reset
    send_item(begin_item(1));
    send_item(select_item());
    it = begin_item(0); it.key_hash = 32'hFFFF_FFFF;
    send_item(it);
    repeat (4) send_item(select_item());
    it = begin_item(0); it.key_hash = 32'd0;
    send_item(it);
    send_item(select_item());
    it = noise_fields(); it.mode = MODE_NONE;
    send_item(it);
    send_item(select_item());

    sent = 0;
    for (int ph = 0; sent < 1600; ph++) begin
      base_time += $urandom_range(100, 100000);
      n = ph < 6 ? counts[ph] : ($urandom_range(0, 3) == 0 ? $urandom_range(0, 63)
                                                           : $urandom_range(2, 8));
      for (int i = 0; i < 32; i++) begin
        if ($urandom_range(0, 1)) begin
          send_item(load_item(i, 0));
          sent++;
        end
      end
      sum = 0;
      for (int i = 0; i < (n > 32 ? 32 : n); i++) sum += loaded_weight[i];
      case ($urandom_range(0, 5))
        0:       tw = 0;
        1:       tw = 8160;
        2:       tw = $urandom_range(1, 8160);
        default: tw = sum == 0 ? 1 : (sum > 8160 ? 8160 : sum);
      endcase
      write_cfg(CFG_PEER_COUNT, n);
      write_cfg(CFG_WEIGHT_SUM, tw);
      repeat (12) begin
        send_item(begin_item($urandom_range(0, 9) == 0));
        sent++;
        repeat ($urandom_range(1, 25)) begin
          case ($urandom_range(0, 19))
            0:       begin it = noise_fields(); it.mode = MODE_NONE; end
            1:       it = load_item($urandom_range(0, 31), 0);
            default: it = select_item();
          endcase
          send_item(it);
          sent++;
        end
      end
    end

    @(negedge clk_i);
    start = 1'b0;
    while (sb.expected_results.size() != 0) @(posedge clk_i);
    repeat (2000) @(posedge clk_i);
    if (sb.errors == 0 && sb.expected_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
